>>> sv/srtp_rt_pkg.sv
package srtp_rt_pkg;

  // Default number of sender slots
  localparam int SlotsDefault = 4;

  // Sequence-number midpoint used for rollover guessing
  localparam logic [15:0] HalfSeq = 16'h8000;

  // Operation codes carried in the operation field
  typedef enum logic [1:0] {
    OP_ESTIMATE = 2'd0,
    OP_COMMIT   = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  // Input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sender_id;
    logic [15:0] seq_number;
    logic [31:0] rounds_in;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic        slot_found;
    logic [1:0]  slot_number;
    logic [31:0] rounds_out;
    logic [47:0] packet_index;
  } out_item_t;

endpackage

>>> sv/srtp_rt_table.sv
module srtp_rt_table #(
  parameter int SLOTS = srtp_rt_pkg::SlotsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  srtp_rt_pkg::in_item_t item,
  output srtp_rt_pkg::out_item_t res
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] started_r, started_nxt;
  logic [31:0]      sender_r [SLOTS];
  logic [31:0]      sender_nxt [SLOTS];
  logic [31:0]      rounds_r [SLOTS];
  logic [31:0]      rounds_nxt [SLOTS];
  logic [15:0]      last_r [SLOTS];
  logic [15:0]      last_nxt [SLOTS];

  logic [SLOTS-1:0] hit;
  logic             hit_any, free_any;
  logic [IdxW-1:0]  hit_idx, free_idx, sel_idx;
  logic [31:0]      cur_roc, guess_roc, new_roc;
  logic [15:0]      cur_last, new_last;
  logic             cur_started;

  // Match sender against every slot; pick lowest hit and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      hit[i] = valid_r[i] && (sender_r[i] == item.sender_id);
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign sel_idx     = hit_any ? hit_idx : free_idx;
  assign cur_roc     = hit_any ? rounds_r[hit_idx] : '0;
  assign cur_last    = hit_any ? last_r[hit_idx] : '0;
  assign cur_started = hit_any && started_r[hit_idx];

  // Guess the rollover count around the sequence midpoint
  always_comb begin
    guess_roc = cur_roc;
    if (cur_started) begin
      if (!cur_last[15]) begin
        if ((item.seq_number > cur_last) &&
            (16'(item.seq_number - cur_last) > srtp_rt_pkg::HalfSeq)) begin
          guess_roc = 32'(cur_roc - 32'd1);
        end
      end else if (16'(cur_last - srtp_rt_pkg::HalfSeq) > item.seq_number) begin
        guess_roc = 32'(cur_roc + 32'd1);
      end
    end
  end

  // Advance the stored count only forward on commit
  always_comb begin
    new_roc  = cur_roc;
    new_last = cur_last;
    if (!cur_started) begin
      new_roc  = item.rounds_in;
      new_last = item.seq_number;
    end else if (item.rounds_in == 32'(cur_roc + 32'd1)) begin
      new_roc  = item.rounds_in;
      new_last = item.seq_number;
    end else if ((item.rounds_in == cur_roc) && (item.seq_number > cur_last)) begin
      new_last = item.seq_number;
    end
  end

  // Form the result word and the next table contents
  always_comb begin
    valid_nxt   = valid_r;
    started_nxt = started_r;
    sender_nxt  = sender_r;
    rounds_nxt  = rounds_r;
    last_nxt    = last_r;
    res         = '0;
    case (item.operation)
      srtp_rt_pkg::OP_ESTIMATE: begin
        if (hit_any || free_any) begin
          res.slot_found   = 1'b1;
          res.slot_number  = 2'(sel_idx);
          res.rounds_out   = guess_roc;
          res.packet_index = {guess_roc, item.seq_number};
          if (!hit_any) begin
            valid_nxt[sel_idx]   = 1'b1;
            started_nxt[sel_idx] = 1'b0;
            sender_nxt[sel_idx]  = item.sender_id;
            rounds_nxt[sel_idx]  = '0;
            last_nxt[sel_idx]    = '0;
          end
        end else begin
          res.packet_index = 48'(item.seq_number);
        end
      end
      srtp_rt_pkg::OP_COMMIT: begin
        if (hit_any) begin
          started_nxt[hit_idx] = 1'b1;
          rounds_nxt[hit_idx]  = new_roc;
          last_nxt[hit_idx]    = new_last;
          res.slot_found       = 1'b1;
          res.slot_number      = 2'(hit_idx);
          res.rounds_out       = new_roc;
          res.packet_index     = {new_roc, new_last};
        end
      end
      srtp_rt_pkg::OP_CLEAR: begin
        valid_nxt   = '0;
        started_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold slot flags; reset empties the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      started_r <= '0;
    end else if (en) begin
      valid_r   <= valid_nxt;
      started_r <= started_nxt;
    end
  end

  // Hold slot contents; only read while the slot is valid
  always_ff @(posedge clk) begin
    if (en) begin
      sender_r <= sender_nxt;
      rounds_r <= rounds_nxt;
      last_r   <= last_nxt;
    end
  end

  // A sender never sits in two slots at once
  a_unique_sender: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("sender held in more than one slot");

  // A started slot is always a claimed slot
  a_started_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r & ~valid_r) == '0)
    else $error("started flag set on a free slot");

  // Clear empties every slot
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    en && (item.operation == srtp_rt_pkg::OP_CLEAR) |=> valid_r == '0)
    else $error("table not empty after clear");

endmodule

>>> sv/srtp_rollover_tracker.sv
// Channel | Direction | Handshake           | Word
// in_     | input     | in_valid / in_stall | srtp_rt_pkg::in_item_t
// out_    | output    | out_valid/out_stall | srtp_rt_pkg::out_item_t
//
// One result word per input word. A word can be taken every cycle unless
// in_stall is high; table lookup, guess and update run between the input
// register and the result register, and the table state is written as the
// word moves into the result register, so the next word sees it.
// Reset empties the table and drops any word in flight.
// in_stall rises only when the input register holds a word and the result
// register is full and stalled.
module srtp_rollover_tracker #(
  parameter int SLOTS = srtp_rt_pkg::SlotsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  srtp_rt_pkg::in_item_t  in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output srtp_rt_pkg::out_item_t out_word
);

  logic                   item_valid_r;
  srtp_rt_pkg::in_item_t  item_r;
  logic                   out_valid_r;
  srtp_rt_pkg::out_item_t out_r;
  srtp_rt_pkg::out_item_t res;
  logic                   out_free;
  logic                   advance;

  // Move the held word on when the result register is free or draining
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;

  // Look up, guess and update the slot table
  srtp_rt_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance),
    .item (item_r),
    .res  (res)
  );

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        item_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  // Capture words
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_word;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> dv/tb_top.sv
module tb_top;

  localparam int NUM_SLOTS = srtp_rt_pkg::SlotsDefault;
  localparam int POOL = 6;
  // Operation code with no meaning: the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  srtp_rt_pkg::in_item_t  in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  srtp_rt_pkg::out_item_t out_word;

  srtp_rollover_tracker #(.SLOTS(NUM_SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // Shadow copy of the sender table
  logic        tab_valid   [NUM_SLOTS] = '{default: 1'b0};
  logic [31:0] tab_sender  [NUM_SLOTS] = '{default: 32'd0};
  logic [31:0] tab_roc     [NUM_SLOTS] = '{default: 32'd0};
  logic [15:0] tab_last    [NUM_SLOTS] = '{default: 16'd0};
  logic        tab_started [NUM_SLOTS] = '{default: 1'b0};

  srtp_rt_pkg::out_item_t expected_words[$];
  srtp_rt_pkg::out_item_t last_result;
  bit          idle_on = 1'b1;
  int          fail_count = 0;
  int          op_count [4] = '{default: 0};
  int          n_full = 0;
  int          n_roc_moves = 0;
  int          stall_left = 0;

  // Per-sender stream state for the session traffic
  logic [31:0] pool_id  [POOL];
  logic [15:0] pool_seq [POOL];

  function automatic srtp_rt_pkg::in_item_t make_word(logic [1:0] op, logic [31:0] id,
                                                      logic [15:0] seq, logic [31:0] r);
    return {op, id, seq, r};
  endfunction

  // Apply one word to the shadow table and return the result it must produce
  function automatic srtp_rt_pkg::out_item_t track_word(input srtp_rt_pkg::in_item_t w);
    srtp_rt_pkg::out_item_t res;
    int          s;
    int          i;
    logic [31:0] guess;
    res = '0;
    s = -1;
    op_count[w.operation]++;
    for (i = 0; i < NUM_SLOTS; i++)
      if (s < 0 && tab_valid[i] && tab_sender[i] == w.sender_id) s = i;
    case (w.operation)
      srtp_rt_pkg::OP_ESTIMATE: begin
        // claim the lowest free slot for a new sender
        if (s < 0) begin
          for (i = 0; i < NUM_SLOTS; i++)
            if (s < 0 && !tab_valid[i]) s = i;
          if (s >= 0) begin
            tab_valid[s] = 1'b1;
            tab_sender[s] = w.sender_id;
            tab_roc[s] = 32'd0;
            tab_last[s] = 16'd0;
            tab_started[s] = 1'b0;
          end
        end
        if (s < 0) begin
          res.packet_index = {32'd0, w.seq_number};
          n_full++;
        end else begin
          guess = tab_roc[s];
          if (tab_started[s]) begin
            if (tab_last[s] < srtp_rt_pkg::HalfSeq) begin
              if (w.seq_number > tab_last[s] &&
                  w.seq_number - tab_last[s] > srtp_rt_pkg::HalfSeq)
                guess = tab_roc[s] - 32'd1;
            end else if (tab_last[s] - srtp_rt_pkg::HalfSeq > w.seq_number) begin
              guess = tab_roc[s] + 32'd1;
            end
          end
          if (guess != tab_roc[s]) n_roc_moves++;
          res.slot_found = 1'b1;
          res.slot_number = s[1:0];
          res.rounds_out = guess;
          res.packet_index = {guess, w.seq_number};
        end
      end
      srtp_rt_pkg::OP_COMMIT: begin
        // advance the stored count only forward; unknown senders change nothing
        if (s >= 0) begin
          if (!tab_started[s]) begin
            tab_started[s] = 1'b1;
            tab_roc[s] = w.rounds_in;
            tab_last[s] = w.seq_number;
          end else if (w.rounds_in == tab_roc[s] + 32'd1) begin
            tab_roc[s] = w.rounds_in;
            tab_last[s] = w.seq_number;
          end else if (w.rounds_in == tab_roc[s] && w.seq_number > tab_last[s]) begin
            tab_last[s] = w.seq_number;
          end
          res.slot_found = 1'b1;
          res.slot_number = s[1:0];
          res.rounds_out = tab_roc[s];
          res.packet_index = {tab_roc[s], tab_last[s]};
        end
      end
      srtp_rt_pkg::OP_CLEAR: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          tab_valid[i] = 1'b0;
          tab_sender[i] = 32'd0;
          tab_roc[i] = 32'd0;
          tab_last[i] = 16'd0;
          tab_started[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Present one word, hold it until taken, then record what it must produce
  task automatic send_word(input srtp_rt_pkg::in_item_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    last_result = track_word(w);
    expected_words.push_back(last_result);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Random stall bursts on the result side
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 10));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Sample at the falling edge; the word is taken at the next rising edge
  always @(negedge clk) begin : check_results
    srtp_rt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, got %h",
                 $time, out_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("slot_found", 48'(want.slot_found), 48'(out_word.slot_found));
        check_field("slot_number", 48'(want.slot_number), 48'(out_word.slot_number));
        check_field("rounds_out", 48'(want.rounds_out), 48'(out_word.rounds_out));
        check_field("packet_index", want.packet_index, out_word.packet_index);
      end
    end
  end

  // Edge cases: midpoint boundaries, count wrap from all ones to zero, full table, clear
  task automatic test_directed();
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h0010, 32'hFFFF_FFFF));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'h0010, 32'hFFFF_FFFF));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'hFFF0, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h8010, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h8011, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'hFFFF, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h0000, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h7FFF, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'h0100, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'h0005, 32'h5));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'h0002, 32'h1));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h0, 16'h0009, 32'h1));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h1234_5678, 16'h4444, 32'h7));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h1234_5678, 16'h0001, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h8000_0001, 16'h8000, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h5555_AAAA, 16'h1234, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'h5555_AAAA, 16'h1234, 32'h3));
    send_word(make_word(srtp_rt_pkg::OP_COMMIT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF));
    send_word(make_word(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(srtp_rt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h5555_AAAA, 16'hAAAA, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h0, 16'h0000, 32'h0));
    send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, 32'h5555_AAAA, 16'hAAAA, 32'h0));
  endtask

  // Packet streams from more senders than slots: estimate, then usually commit
  task automatic test_sessions(input int steps);
    int          k;
    int          pick;
    logic [31:0] rounds;
    for (k = 0; k < POOL; k++) begin
      pool_id[k] = $urandom;
      pool_seq[k] = 16'($urandom);
    end
    repeat (steps) begin
      k = int'($urandom_range(0, POOL - 1));
      pick = int'($urandom_range(0, 99));
      if (pick < 70) pool_seq[k] = 16'(pool_seq[k] + $urandom_range(1, 64));
      else if (pick < 80) pool_seq[k] = 16'(pool_seq[k] + $urandom_range('h7000, 'h9000));
      else if (pick < 90) pool_seq[k] = 16'(pool_seq[k] - $urandom_range(1, 64));
      else pool_seq[k] = 16'($urandom);
      send_word(make_word(srtp_rt_pkg::OP_ESTIMATE, pool_id[k], pool_seq[k], $urandom));
      pick = int'($urandom_range(0, 99));
      if (pick < 2) begin
        send_word(make_word(srtp_rt_pkg::OP_CLEAR, $urandom, 16'($urandom), $urandom));
      end else if (pick < 87) begin
        rounds = last_result.rounds_out;
        // a fresh slot joins at some count, the extremes among them
        if (last_result.slot_found && !tab_started[last_result.slot_number]) begin
          case ($urandom_range(0, 3))
            0: rounds = 32'd0;
            1: rounds = 32'hFFFF_FFFF;
            2: rounds = 32'hFFFF_FFFE;
            default: rounds = $urandom;
          endcase
        end else if ($urandom_range(0, 19) == 0) begin
          rounds = $urandom;
        end
        send_word(make_word(srtp_rt_pkg::OP_COMMIT, pool_id[k], pool_seq[k], rounds));
      end
    end
  endtask

  // Unstructured words of every code, half of them aimed at known senders
  task automatic test_noise(input int count);
    logic [31:0] id;
    repeat (count) begin
      id = $urandom_range(0, 1) ? pool_id[$urandom_range(0, POOL - 1)] : $urandom;
      send_word(make_word(2'($urandom_range(0, 3)), id, 16'($urandom), $urandom));
    end
  endtask

  initial begin
    #10_000_000;
    $display("Time limit reached");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_for_results();
    test_sessions(520);
    wait_for_results();
    test_noise(250);
    wait_for_results();
    // finish at full rate, no gaps on either side
    idle_on = 1'b0;
    test_sessions(150);
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d estimates, %0d commits, %0d clears and %0d unused codes",
             op_count[srtp_rt_pkg::OP_ESTIMATE], op_count[srtp_rt_pkg::OP_COMMIT],
             op_count[srtp_rt_pkg::OP_CLEAR], op_count[OP_UNUSED]);
    $display("%0d guesses moved the count, %0d estimates met a full table",
             n_roc_moves, n_full);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
